@@ sv/sews_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sews_pkg
// Shared types and constants of the scanline edge walker / span setup block.
// ----------------------------------------------------------------------------
package sews_pkg;

    localparam int unsigned CLIP_MAX = 4096;

    localparam logic CFG_CLIP_WIDTH  = 1'b0;
    localparam logic CFG_CLIP_HEIGHT = 1'b1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_ROW  = 1'b1;

    // multiplier sequence step codes
    localparam logic [3:0] MS_TEX_LO   = 4'd0;
    localparam logic [3:0] MS_TEX_HI   = 4'd1;
    localparam logic [3:0] MS_COL_L0   = 4'd2;
    localparam logic [3:0] MS_COL_L1   = 4'd3;
    localparam logic [3:0] MS_COL_L2   = 4'd4;
    localparam logic [3:0] MS_COL_L3   = 4'd5;
    localparam logic [3:0] MS_Z        = 4'd6;
    localparam logic [3:0] MS_SKIP_TLO = 4'd7;
    localparam logic [3:0] MS_SKIP_THI = 4'd8;
    localparam logic [3:0] MS_SKIP_CLO = 4'd9;
    localparam logic [3:0] MS_SKIP_CHI = 4'd10;
    localparam logic [3:0] MS_SKIP_Z   = 4'd11;
    localparam logic [3:0] MS_DONE     = 4'd12;

    typedef struct packed {
        logic               kind;
        logic               edge_side;
        logic [1:0]         attr_select;
        logic [63:0]        pos_value;
        logic [63:0]        step_value;
        logic signed [15:0] row_y;
    } sews_in_t;

    typedef struct packed {
        logic               draw;
        logic [11:0]        span_x;
        logic [12:0]        span_count;
        logic [63:0]        tex_start;
        logic [63:0]        tex_step;
        logic [63:0]        color_start;
        logic [63:0]        color_step;
        logic signed [31:0] z_start;
        logic signed [31:0] z_step;
    } sews_out_t;

    typedef struct packed {
        logic [12:0] clip_width;
        logic [12:0] clip_height;
    } sews_cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } sews_state_t;

endpackage
`default_nettype wire

@@ sv/sews_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sews_front
// Input side: accepts load and row items into a short queue for the engine.
// ----------------------------------------------------------------------------
module sews_front
    import sews_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire sews_in_t in_data,
    output logic          q_valid,
    output sews_in_t      q_data,
    input  wire logic     q_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sews_in_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push;
    logic             pop;

    assign in_stall = (cnt_reg == CNT_FULL);
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule
`default_nettype wire

@@ sv/sews_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sews_back
// Engine: edge state, reciprocal divider, shared multiplier sequence, clip.
// ----------------------------------------------------------------------------
module sews_back
    import sews_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire sews_cfg_t cfg,
    input  wire logic      q_valid,
    input  wire sews_in_t  q_data,
    output logic           q_pop,
    output logic           out_valid,
    input  wire logic      out_stall,
    output sews_out_t      out_data
);

    sews_state_t state_reg, state_next;

    logic [63:0]        pos_reg [8];
    logic [63:0]        inc_reg [8];
    logic signed [15:0] x0_reg, x1_reg, y_reg;
    logic [63:0]        tdiff_reg, cdiff_reg;
    logic [31:0]        zdiff_reg;
    logic [63:0]        tp_reg, cp_reg, ts_reg, cs_reg;
    logic [31:0]        zp_reg, zs_reg;
    logic [16:0]        skip_reg;
    logic [15:0]        divisor_reg;
    logic               cnt_pos_reg;
    logic [16:0]        rem_reg, quo_reg;
    logic [4:0]         bit_reg;
    logic [3:0]         mul_cnt_reg, pstep_reg;
    logic               pv_reg;
    logic signed [50:0] prod_reg;
    logic               out_valid_reg;
    sews_out_t          out_reg;
    sews_out_t          out_next;

    logic               out_free;
    logic signed [16:0] cnt;
    logic [16:0]        rem_sh;
    logic               ge;
    logic [16:0]        rcp;
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic [1:0]         lane_i, lane_c;
    logic [12:0]        w_clip, h_clip;
    logic signed [16:0] start_s, end_s, x1_s;
    logic signed [17:0] span_len;
    logic               draw;
    logic [31:0]        adv32 [8];

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign cnt = {pos_reg[4][31], pos_reg[4][31:16]} - {pos_reg[0][31], pos_reg[0][31:16]};

    assign rem_sh = {rem_reg[15:0], (bit_reg == 5'd16)};
    assign ge     = (rem_sh >= {1'b0, divisor_reg});
    assign rcp    = cnt_pos_reg ? quo_reg : '0;

    assign lane_i = mul_cnt_reg[1:0] - 2'd2;
    assign lane_c = pstep_reg[1:0] - 2'd2;

    always_comb
    begin
        mul_a = '0;
        mul_b = {1'b0, rcp};
        case (mul_cnt_reg)
            MS_TEX_LO: mul_a = {1'b0, tdiff_reg[31:0]};
            MS_TEX_HI: mul_a = {1'b0, tdiff_reg[63:32]};
            MS_COL_L0, MS_COL_L1, MS_COL_L2, MS_COL_L3:
                mul_a = {17'd0, cdiff_reg[16*lane_i +: 16]};
            MS_Z:      mul_a = {zdiff_reg[31], zdiff_reg};
            MS_SKIP_TLO:
            begin
                mul_a = {1'b0, ts_reg[31:0]};
                mul_b = {1'b0, skip_reg};
            end
            MS_SKIP_THI:
            begin
                mul_a = {1'b0, ts_reg[63:32]};
                mul_b = {1'b0, skip_reg};
            end
            MS_SKIP_CLO:
            begin
                mul_a = {1'b0, cs_reg[31:0]};
                mul_b = {1'b0, skip_reg};
            end
            MS_SKIP_CHI:
            begin
                mul_a = {1'b0, cs_reg[63:32]};
                mul_b = {1'b0, skip_reg};
            end
            MS_SKIP_Z:
            begin
                mul_a = {1'b0, zs_reg};
                mul_b = {1'b0, skip_reg};
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // clip and span length
    always_comb
    begin
        w_clip   = (cfg.clip_width  > 13'(CLIP_MAX)) ? 13'(CLIP_MAX) : cfg.clip_width;
        h_clip   = (cfg.clip_height > 13'(CLIP_MAX)) ? 13'(CLIP_MAX) : cfg.clip_height;
        start_s  = x0_reg[15] ? 17'sd0 : {1'b0, x0_reg};
        x1_s     = {x1_reg[15], x1_reg};
        end_s    = (x1_s < $signed({4'd0, w_clip})) ? x1_s : $signed({4'd0, w_clip});
        span_len = {end_s[16], end_s} - {start_s[16], start_s};
        draw     = !y_reg[15] && (y_reg < $signed({3'd0, h_clip}))
                   && !span_len[17] && (span_len != '0);
    end

    always_comb
    begin
        out_next = '0;
        if (draw)
        begin
            out_next.draw        = 1'b1;
            out_next.span_x      = start_s[11:0];
            out_next.span_count  = span_len[12:0];
            out_next.tex_start   = tp_reg;
            out_next.tex_step    = ts_reg;
            out_next.color_start = cp_reg;
            out_next.color_step  = cs_reg;
            out_next.z_start     = $signed(zp_reg);
            out_next.z_step      = $signed(zs_reg);
        end
    end

    // x and z advance in 32 bits, stored sign-extended
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            adv32[i] = pos_reg[i][31:0] + inc_reg[i][31:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_data.kind == KIND_ROW)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (bit_reg == '0)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_cnt_reg == MS_DONE)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop = 1'b0;
        case (state_reg)
            ST_IDLE: q_pop = q_valid;
            default: q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pv_reg        <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                pos_reg[i] <= '0;
                inc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            pv_reg <= (state_reg == ST_MUL) && (mul_cnt_reg != MS_DONE);
            if (state_reg == ST_IDLE && q_valid)
            begin
                if (q_data.kind == KIND_LOAD)
                begin
                    pos_reg[{q_data.edge_side, q_data.attr_select}] <= q_data.pos_value;
                    inc_reg[{q_data.edge_side, q_data.attr_select}] <= q_data.step_value;
                end
                else
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        if ((i % 4) == 0 || (i % 4) == 3)
                        begin
                            pos_reg[i] <= {{32{adv32[i][31]}}, adv32[i]};
                        end
                        else
                        begin
                            pos_reg[i] <= pos_reg[i] + inc_reg[i];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                x0_reg      <= $signed(pos_reg[0][31:16]);
                x1_reg      <= $signed(pos_reg[4][31:16]);
                y_reg       <= q_data.row_y;
                tdiff_reg   <= pos_reg[5] - pos_reg[1];
                cdiff_reg   <= pos_reg[6] - pos_reg[2];
                zdiff_reg   <= pos_reg[7][31:0] - pos_reg[3][31:0];
                tp_reg      <= pos_reg[1];
                cp_reg      <= pos_reg[2];
                zp_reg      <= pos_reg[3][31:0];
                skip_reg    <= pos_reg[0][31] ? 17'd0 - {1'b1, pos_reg[0][31:16]} : 17'd0;
                divisor_reg <= cnt[15:0];
                cnt_pos_reg <= !cnt[16] && (cnt != '0);
                rem_reg     <= '0;
                quo_reg     <= '0;
                bit_reg     <= 5'd16;
                mul_cnt_reg <= MS_TEX_LO;
            end
            ST_DIV:
            begin
                rem_reg <= ge ? rem_sh - {1'b0, divisor_reg} : rem_sh;
                quo_reg <= {quo_reg[15:0], ge};
                bit_reg <= bit_reg - 1'b1;
            end
            ST_MUL:
            begin
                if (mul_cnt_reg != MS_DONE)
                begin
                    prod_reg    <= 51'(mul_a * mul_b);
                    pstep_reg   <= mul_cnt_reg;
                    mul_cnt_reg <= mul_cnt_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_reg <= out_next;
                end
            end
            default:
            begin
                bit_reg <= '0;
            end
        endcase

        // products are registered in prod_reg, then written to their destination
        if (pv_reg)
        begin
            case (pstep_reg)
                MS_TEX_LO: ts_reg[31:0]  <= prod_reg[47:16];
                MS_TEX_HI: ts_reg[63:32] <= prod_reg[47:16];
                MS_COL_L0, MS_COL_L1, MS_COL_L2, MS_COL_L3:
                    cs_reg[16*lane_c +: 16] <= prod_reg[31:16];
                MS_Z:        zs_reg <= prod_reg[47:16];
                MS_SKIP_TLO: tp_reg <= tp_reg + {13'd0, $unsigned(prod_reg)};
                MS_SKIP_THI: tp_reg[63:32] <= tp_reg[63:32] + prod_reg[31:0];
                MS_SKIP_CLO: cp_reg <= cp_reg + {13'd0, $unsigned(prod_reg)};
                MS_SKIP_CHI: cp_reg[63:32] <= cp_reg[63:32] + prod_reg[31:0];
                MS_SKIP_Z:   zp_reg <= zp_reg + prod_reg[31:0];
                default:     zs_reg <= zs_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ sv/scanline_edge_walk_span_setup_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scanline_edge_walk_span_setup_top
// Edge walker: keeps left/right edge attributes, turns each row into a span.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   sews_in_t
//   out      output     out_valid / out_stall sews_out_t
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Load items are written to the edge state while the engine is idle. Row
// items hold the engine through setup, the bit-serial reciprocal divider,
// the shared multiplier sequence and output; the span goes to the output
// register once it is free. Reset clears all edge state and sets the clip to
// 320 x 200. The two-entry input queue keeps taking items, until it is full,
// while the engine works or while the output register is stalled.
// ----------------------------------------------------------------------------
module scanline_edge_walk_span_setup_top
    import sews_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire sews_in_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output sews_out_t        out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [12:0] cfg_data
);

    sews_cfg_t cfg_reg;
    logic      q_valid;
    sews_in_t  q_data;
    logic      q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= {13'd320, 13'd200};
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CLIP_WIDTH:  cfg_reg.clip_width  <= cfg_data;
                CFG_CLIP_HEIGHT: cfg_reg.clip_height <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    sews_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    sews_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire
